// ----- rtl/mhc_pkg.sv -----
package mhc_pkg;

  localparam int MHC_SAMPLE_WIDTH = 16;
  localparam int MHC_CORDIC_STEPS = 16;
  localparam int MHC_STEP_W       = $clog2(MHC_CORDIC_STEPS);
  localparam int MHC_CW           = 33;  // CORDIC x/y, operands below 2^30 plus gain
  localparam int MHC_ZW           = 24;  // angle, degrees Q16
  localparam int MHC_FRAC         = 16;
  localparam int MHC_ATAN_W       = 22;

  localparam logic [1:0] MHC_OP_CAL   = 2'd0;
  localparam logic [1:0] MHC_OP_HEAD  = 2'd1;
  localparam logic [1:0] MHC_OP_CLEAR = 2'd2;

  localparam logic [8:0] MHC_BASE_0   = 9'd0;
  localparam logic [8:0] MHC_BASE_90  = 9'd90;
  localparam logic [8:0] MHC_BASE_180 = 9'd180;
  localparam logic [8:0] MHC_BASE_270 = 9'd270;
  localparam logic [6:0] MHC_DEG_MAX  = 7'd89;
  localparam logic [8:0] MHC_HEADING_MAX = 9'd359;

  // atan(2^-i) in degrees, Q16
  localparam logic [MHC_ATAN_W-1:0] MHC_ATAN [MHC_CORDIC_STEPS] = '{
    22'd2949120, 22'd1740967, 22'd919879, 22'd466945,
    22'd234379,  22'd117304,  22'd58666,  22'd29335,
    22'd14668,   22'd7334,    22'd3667,   22'd1833,
    22'd917,     22'd458,     22'd229,    22'd115
  };

  typedef struct packed {
    logic                  load;
    logic                  prep;
    logic                  mul_x;
    logic                  mul_y;
    logic                  quad;
    logic                  norm;
    logic                  rot;
    logic [MHC_STEP_W-1:0] step;
    logic                  finish;
  } mhc_cmd_t;

  typedef struct packed {
    logic go;
    logic norm_done;
  } mhc_status_t;

endpackage

// ----- rtl/mhc_in_if.sv -----
interface mhc_in_if import mhc_pkg::*; #(
  parameter int W = MHC_SAMPLE_WIDTH
) ();
  logic                valid;
  logic                ready;
  logic [1:0]          op;
  logic signed [W-1:0] raw_x;
  logic signed [W-1:0] raw_y;

  modport source (output valid, op, raw_x, raw_y, input ready);
  modport sink   (input valid, op, raw_x, raw_y, output ready);
endinterface

// ----- rtl/mhc_out_if.sv -----
interface mhc_out_if ();
  logic       valid;
  logic       ready;
  logic [8:0] heading_deg;
  logic       heading_valid;
  logic       cal_ready;

  modport source (output valid, heading_deg, heading_valid, cal_ready, input ready);
  modport sink   (input valid, heading_deg, heading_valid, cal_ready, output ready);
endinterface

// ----- rtl/mhc_ctrl.sv -----
module mhc_ctrl import mhc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  output mhc_cmd_t    cmd,
  input  mhc_status_t status
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_PREP = 8'b0000_0010,
    S_MULX = 8'b0000_0100,
    S_MULY = 8'b0000_1000,
    S_QUAD = 8'b0001_0000,
    S_NORM = 8'b0010_0000,
    S_ROT  = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_t;

  localparam logic [MHC_STEP_W-1:0] LastStep = MHC_STEP_W'(MHC_CORDIC_STEPS - 1);

  state_t                state, state_next;
  logic [MHC_STEP_W-1:0] step, step_next;
  logic                  out_valid_next;
  logic                  can_finish;

  assign in_ready   = (state == S_IDLE);
  assign can_finish = (state == S_DONE) && (!out_valid || out_ready);

  always_comb begin
    cmd        = '0;
    cmd.load   = in_valid && in_ready;
    cmd.prep   = (state == S_PREP);
    cmd.mul_x  = (state == S_MULX);
    cmd.mul_y  = (state == S_MULY);
    cmd.quad   = (state == S_QUAD);
    cmd.norm   = (state == S_NORM);
    cmd.rot    = (state == S_ROT);
    cmd.step   = step;
    cmd.finish = can_finish;
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    unique case (state)
      S_IDLE: if (in_valid) state_next = S_PREP;
      S_PREP: state_next = S_MULX;
      S_MULX: state_next = S_MULY;
      S_MULY: state_next = S_QUAD;
      S_QUAD: state_next = status.go ? S_NORM : S_DONE;
      S_NORM: begin
        step_next = '0;
        if (status.norm_done) state_next = S_ROT;
      end
      S_ROT: begin
        step_next = step + 1'b1;
        if (step == LastStep) state_next = S_DONE;
      end
      S_DONE: if (can_finish) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (out_valid && out_ready) out_valid_next = 1'b0;
    if (can_finish) out_valid_next = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step      <= step_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ----- rtl/mhc_dp.sv -----
module mhc_dp import mhc_pkg::*; #(
  parameter int SAMPLE_WIDTH = MHC_SAMPLE_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  mhc_cmd_t                      cmd,
  output mhc_status_t                   status,
  input  logic [1:0]                    in_op,
  input  logic signed [SAMPLE_WIDTH-1:0] in_x,
  input  logic signed [SAMPLE_WIDTH-1:0] in_y,
  output logic [8:0]                    heading_deg,
  output logic                          heading_valid,
  output logic                          cal_ready
);

  localparam int W  = SAMPLE_WIDTH;
  localparam int DW = W + 2;
  localparam int RW = W + 1;
  localparam int PW = DW + RW;
  localparam int NW = (PW > 31) ? PW : 31;
  localparam int CW = MHC_CW;
  localparam int ZW = MHC_ZW;

  logic [1:0]           op_r;
  logic signed [W-1:0]  x_r, y_r;
  logic signed [W-1:0]  x_max, x_min, y_max, y_min;
  logic signed [DW-1:0] dx, dy;
  logic signed [RW-1:0] rx, ry;
  logic                 cal_r;
  logic signed [PW-1:0] prod_x, prod_y, mul_p;
  logic signed [DW-1:0] mul_a;
  logic signed [RW-1:0] mul_b;
  logic                 vld_r;
  logic [8:0]           base_r;
  logic [NW-1:0]        adj, opp, m;
  logic signed [CW-1:0] cx, cy;
  logic signed [ZW-1:0] cz;

  // trackers
  always_ff @(posedge clk) begin
    if (rst) begin
      x_max <= '0;
      x_min <= '0;
      y_max <= '0;
      y_min <= '0;
    end else if (cmd.load) begin
      case (in_op)
        MHC_OP_CAL: begin
          if (in_x > x_max) x_max <= in_x;
          if (in_x < x_min) x_min <= in_x;
          if (in_y > y_max) y_max <= in_y;
          if (in_y < y_min) y_min <= in_y;
        end
        MHC_OP_CLEAR: begin
          x_max <= '0;
          x_min <= '0;
          y_max <= '0;
          y_min <= '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= in_op;
      x_r  <= in_x;
      y_r  <= in_y;
    end
  end

  // centering and ranges
  logic signed [RW-1:0] rx_c, ry_c;
  assign rx_c = RW'(x_max) - RW'(x_min);
  assign ry_c = RW'(y_max) - RW'(y_min);

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      dx    <= (DW'(x_r) <<< 1) - DW'(x_max) - DW'(x_min);
      dy    <= (DW'(y_r) <<< 1) - DW'(y_max) - DW'(y_min);
      rx    <= rx_c;
      ry    <= ry_c;
      cal_r <= (rx_c != '0) && (ry_c != '0);
    end
  end

  // one shared multiplier, x product then y product
  assign mul_a = cmd.mul_y ? dy : dx;
  assign mul_b = cmd.mul_y ? rx : ry;
  assign mul_p = PW'(mul_a) * PW'(mul_b);

  always_ff @(posedge clk) begin
    if (cmd.mul_x) prod_x <= mul_p;
    if (cmd.mul_y) prod_y <= mul_p;
  end

  // quadrant select
  logic [PW-1:0] ax, ay;
  logic          x_neg, y_neg, x_zero, y_zero, go;
  assign x_neg  = prod_x[PW-1];
  assign y_neg  = prod_y[PW-1];
  assign x_zero = (prod_x == '0);
  assign y_zero = (prod_y == '0);
  assign ax     = x_neg ? PW'(-prod_x) : PW'(prod_x);
  assign ay     = y_neg ? PW'(-prod_y) : PW'(prod_y);
  assign go     = (op_r == MHC_OP_HEAD) && cal_r && !(x_zero && y_zero);

  // normalizer: larger operand into [2^29, 2^30)
  logic big4, big1, small4, small1;
  assign m      = (adj > opp) ? adj : opp;
  assign big4   = |(m >> 34);
  assign big1   = |(m >> 30);
  assign small4 = ~|(m >> 25);
  assign small1 = ~|(m >> 29);

  assign status.go        = go;
  assign status.norm_done = !big1 && !small1;

  always_ff @(posedge clk) begin
    if (cmd.quad) begin
      vld_r <= go;
      if (!x_neg && !x_zero && !y_neg) begin
        base_r <= MHC_BASE_0;
        adj    <= NW'(ax);
        opp    <= NW'(ay);
      end else if ((x_neg || x_zero) && !y_neg && !y_zero) begin
        base_r <= MHC_BASE_90;
        adj    <= NW'(ay);
        opp    <= NW'(ax);
      end else if (x_neg && (y_neg || y_zero)) begin
        base_r <= MHC_BASE_180;
        adj    <= NW'(ax);
        opp    <= NW'(ay);
      end else begin
        base_r <= MHC_BASE_270;
        adj    <= NW'(ay);
        opp    <= NW'(ax);
      end
    end else if (cmd.norm) begin
      if (big4) begin
        adj <= adj >> 4;
        opp <= opp >> 4;
      end else if (big1) begin
        adj <= adj >> 1;
        opp <= opp >> 1;
      end else if (small4) begin
        adj <= adj << 4;
        opp <= opp << 4;
      end else if (small1) begin
        adj <= adj << 1;
        opp <= opp << 1;
      end
    end
  end

  // CORDIC vectoring, one micro-rotation per cycle
  logic signed [CW-1:0] sx, sy;
  logic signed [ZW-1:0] at;
  assign sx = cx >>> cmd.step;
  assign sy = cy >>> cmd.step;
  assign at = ZW'(MHC_ATAN[cmd.step]);

  always_ff @(posedge clk) begin
    if (cmd.norm && status.norm_done) begin
      cx <= CW'(adj[29:0]);
      cy <= CW'(opp[29:0]);
      cz <= '0;
    end else if (cmd.rot) begin
      if (cy > 0) begin
        cx <= cx + sy;
        cy <= cy - sx;
        cz <= cz + at;
      end else begin
        cx <= cx - sy;
        cy <= cy + sx;
        cz <= cz - at;
      end
    end
  end

  // result
  logic [ZW-MHC_FRAC-1:0] z_int;
  logic [6:0]             deg;
  assign z_int = cz[ZW-1:MHC_FRAC];
  always_comb begin
    if (cz[ZW-1])                               deg = '0;
    else if (z_int > (ZW-MHC_FRAC)'(MHC_DEG_MAX)) deg = MHC_DEG_MAX;
    else                                        deg = z_int[6:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      heading_deg   <= vld_r ? (base_r + 9'(deg)) : '0;
      heading_valid <= vld_r;
      cal_ready     <= cal_r;
    end
  end

endmodule

// ----- rtl/magnetometer_heading_calibrated.sv -----
// Hard-iron calibrated compass heading. Each input beat carries an op and a signed raw X/Y
// sample: op 0 widens the per-axis min/max trackers, op 2 clears them to zero, op 1 returns
// atan2 of the sample centered on each axis midpoint and scaled by the inverse axis range,
// in whole degrees 0..359 (rounded down). heading_valid is low for non-heading ops, a zero
// range on either axis or a zero centered vector; heading_deg is then 0. cal_ready reports
// both ranges nonzero after the beat's update. One beat is in flight at a time; ready is
// high only while idle. Calibration and clear beats pass through centering, both products and
// the quadrant pick, then skip to the output. A heading beat runs centering, the two products
// on one shared multiplier and the quadrant pick, the normalizing shifter, 16 CORDIC
// micro-rotations and a load of the output register, which holds the result until taken.
module magnetometer_heading_calibrated import mhc_pkg::*; #(
  parameter int SAMPLE_WIDTH = MHC_SAMPLE_WIDTH
) (
  input  logic             clk,
  input  logic             rst,
  mhc_in_if.sink           sample,
  mhc_out_if.source        heading
);

  mhc_cmd_t                       cmd;
  mhc_status_t                    status;
  logic                           in_ready;
  logic                           out_valid;
  logic signed [SAMPLE_WIDTH-1:0] in_x, in_y;

  assign in_x         = sample.raw_x;
  assign in_y         = sample.raw_y;
  assign sample.ready = in_ready;
  assign heading.valid = out_valid;

  mhc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sample.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (heading.ready),
    .cmd       (cmd),
    .status    (status)
  );

  mhc_dp #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .in_op         (sample.op),
    .in_x          (in_x),
    .in_y          (in_y),
    .heading_deg   (heading.heading_deg),
    .heading_valid (heading.heading_valid),
    .cal_ready     (heading.cal_ready)
  );

endmodule

// ----- rtl/mhc_checker.sv -----
module mhc_checker import mhc_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [8:0] heading_deg,
  input logic       heading_valid,
  input logic       cal_ready
);

  // one beat in flight
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a beat is in flight");

  a_heading_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && heading_valid |-> heading_deg <= MHC_HEADING_MAX)
    else $error("heading out of range");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !heading_valid |-> heading_deg == 9'd0)
    else $error("invalid heading not zero");

  a_valid_needs_cal: assert property (@(posedge clk) disable iff (rst)
    out_valid && heading_valid |-> cal_ready)
    else $error("heading valid without calibration");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(heading_deg)
      && $stable(heading_valid) && $stable(cal_ready))
    else $error("stalled result changed");

endmodule

bind magnetometer_heading_calibrated mhc_checker u_mhc_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (sample.valid),
  .in_ready      (sample.ready),
  .out_valid     (heading.valid),
  .out_ready     (heading.ready),
  .heading_deg   (heading.heading_deg),
  .heading_valid (heading.heading_valid),
  .cal_ready     (heading.cal_ready)
);
